@@ hdl/assert_macros.svh @@
// Assertion macros shared by the union-find MST block.
// Needs nothing else; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/kufm_pkg.sv @@
// Types and constants of the union-find MST block.
// Used by the controller, the datapath and the top level; depends on nothing.
package kufm_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int NODE_W   = 8;
  localparam int EWEIGHT_W = 16;
  localparam int VCOUNT_W = 9;
  localparam int SUM_W    = 24;
  localparam int TALLY_W  = 8;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;
  localparam logic [SUM_W-1:0]    SUM_MAX      = 24'hFFFFFF;
  localparam logic [TALLY_W-1:0]  TALLY_MAX    = 8'hFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK_A,
    S_WALK_B,
    S_LINK
  } state_t;

  typedef struct packed {
    logic cap;
    logic clr;
    logic rd_a;
    logic walk_a;
    logic walk_b;
    logic link;
    logic refuse;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic gate_ok;
    logic found;
  } sts_t;

endpackage

@@ hdl/kufm_ctrl.sv @@
// Controller of the union-find MST block: clearing pass, root walks, link.
// Depends on kufm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kufm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_restart,
  input  kufm_pkg::sts_t    sts,
  output logic              busy,
  output kufm_pkg::cmd_t    cmd
);

  kufm_pkg::state_t state_r, state_nxt;
  logic             pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kufm_pkg::S_CLEAR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    case (state_r)
      kufm_pkg::S_CLEAR: begin
        if (sts.sweep_last) begin
          state_nxt = pend_r ? kufm_pkg::S_CHECK : kufm_pkg::S_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      kufm_pkg::S_IDLE: begin
        if (start) begin
          if (in_restart) begin
            state_nxt = kufm_pkg::S_CLEAR;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = kufm_pkg::S_CHECK;
          end
        end
      end
      kufm_pkg::S_CHECK: begin
        state_nxt = sts.gate_ok ? kufm_pkg::S_WALK_A : kufm_pkg::S_IDLE;
      end
      kufm_pkg::S_WALK_A: begin
        if (sts.found) state_nxt = kufm_pkg::S_WALK_B;
      end
      kufm_pkg::S_WALK_B: begin
        if (sts.found) state_nxt = kufm_pkg::S_LINK;
      end
      kufm_pkg::S_LINK: begin
        state_nxt = kufm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = kufm_pkg::S_CLEAR;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      kufm_pkg::S_CLEAR:  cmd.clr = 1'b1;
      kufm_pkg::S_IDLE: begin
        busy    = 1'b0;
        cmd.cap = start;
      end
      kufm_pkg::S_CHECK: begin
        cmd.rd_a   = sts.gate_ok;
        cmd.refuse = !sts.gate_ok;
      end
      kufm_pkg::S_WALK_A: cmd.walk_a = 1'b1;
      kufm_pkg::S_WALK_B: cmd.walk_b = 1'b1;
      kufm_pkg::S_LINK:   cmd.link   = 1'b1;
      default:            cmd        = '0;
    endcase
  end

  `ASSERT_NEXT(a_plain_start, clk, rst_n, start && !busy && !in_restart, state_r == kufm_pkg::S_CHECK)
  `ASSERT_ALWAYS(a_cmd_excl, clk, rst_n, $onehot0({cmd.clr, cmd.rd_a, cmd.walk_a, cmd.walk_b, cmd.link, cmd.refuse}))
  `ASSERT_IMPLIES(a_walk_b_entry, clk, rst_n, state_r == kufm_pkg::S_WALK_B, $past(state_r) == kufm_pkg::S_WALK_A || $past(state_r) == kufm_pkg::S_WALK_B)

endmodule

@@ hdl/kufm_dpath.sv @@
// Datapath of the union-find MST block: parent memory, totals, result register.
// Depends on kufm_pkg and assert_macros.svh; driven by kufm_ctrl commands.
`include "assert_macros.svh"

module kufm_dpath #(
  parameter int MAX_VERTICES = kufm_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = kufm_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kufm_pkg::cmd_t                    cmd,
  output kufm_pkg::sts_t                    sts,
  input  logic [kufm_pkg::NODE_W-1:0]       in_from_node,
  input  logic [kufm_pkg::NODE_W-1:0]       in_to_node,
  input  logic [kufm_pkg::EWEIGHT_W-1:0]    in_edge_weight,
  input  logic                              cfg_wr,
  input  logic [kufm_pkg::VCOUNT_W-1:0]     cfg_vertex_count,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic [kufm_pkg::SUM_W-1:0]        out_total_weight,
  output logic [kufm_pkg::TALLY_W-1:0]      out_tree_edges,
  output logic                              out_complete
);

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW0 = $clog2(MAX_VERTICES + 1);
  localparam int NW  = (CW0 > kufm_pkg::VCOUNT_W) ? CW0 : kufm_pkg::VCOUNT_W;
  localparam int WB  = (WEIGHT_BITS < kufm_pkg::EWEIGHT_W) ? WEIGHT_BITS : kufm_pkg::EWEIGHT_W;
  localparam int SW  = kufm_pkg::SUM_W;
  localparam int TW  = kufm_pkg::TALLY_W;

  logic [VW-1:0] parent_mem [MAX_VERTICES];

  logic [kufm_pkg::VCOUNT_W-1:0] vc_r;
  logic [SW-1:0]                 sum_r, sum_nxt;
  logic [TW-1:0]                 tally_r, tally_nxt;
  logic [VW-1:0]                 sweep_r, sweep_nxt;
  logic [kufm_pkg::NODE_W-1:0]   a_r, b_r;
  logic [WB-1:0]                 weight_r;
  logic [VW-1:0]                 cur_r, cur_nxt;
  logic [VW-1:0]                 ra_r;
  logic [VW-1:0]                 rdata_r;

  logic          out_valid_r, out_acc_r, out_cmp_r;
  logic [SW-1:0] out_sum_r;
  logic [TW-1:0] out_tally_r;

  logic [NW-1:0] vc_ext, n_eff, target;
  logic          found, diff, merge;
  logic          rd_en, wr_en;
  logic [VW-1:0] rd_addr, wr_addr, wr_data;
  logic [SW:0]   sum_add;

  assign vc_ext = NW'(vc_r);

  always_comb begin
    if (vc_ext == '0) begin
      n_eff = NW'(1);
    end else if (vc_ext > NW'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = vc_ext;
    end
  end

  assign target = n_eff - NW'(1);

  assign found = (rdata_r == cur_r);
  assign diff  = (ra_r != cur_r);
  assign merge = cmd.link && diff;

  assign sts.sweep_last = (sweep_r == VW'(MAX_VERTICES - 1));
  assign sts.gate_ok    = (NW'(tally_r) < target) && (NW'(a_r) < n_eff) && (NW'(b_r) < n_eff);
  assign sts.found      = found;

  assign sweep_nxt = sts.sweep_last ? '0 : sweep_r + VW'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rdata_r;
    cur_nxt = cur_r;
    if (cmd.rd_a) begin
      rd_en   = 1'b1;
      rd_addr = VW'(a_r);
      cur_nxt = VW'(a_r);
    end else if ((cmd.walk_a || cmd.walk_b) && !found) begin
      rd_en   = 1'b1;
      rd_addr = rdata_r;
      cur_nxt = rdata_r;
    end else if (cmd.walk_a && found) begin
      rd_en   = 1'b1;
      rd_addr = VW'(b_r);
      cur_nxt = VW'(b_r);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_r;
    wr_data = sweep_r;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end else if (merge) begin
      wr_en   = 1'b1;
      wr_addr = (ra_r < cur_r) ? cur_r : ra_r;
      wr_data = (ra_r < cur_r) ? ra_r : cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) parent_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= parent_mem[rd_addr];
  end

  assign sum_add = {1'b0, sum_r} + (SW + 1)'(weight_r);

  always_comb begin
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    if (merge) begin
      sum_nxt   = sum_add[SW] ? kufm_pkg::SUM_MAX : sum_add[SW-1:0];
      tally_nxt = (tally_r == kufm_pkg::TALLY_MAX) ? tally_r : tally_r + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= kufm_pkg::VCOUNT_RESET;
      sum_r       <= '0;
      tally_r     <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) vc_r <= cfg_vertex_count;
      if (cmd.clr) begin
        sum_r   <= '0;
        tally_r <= '0;
        sweep_r <= sweep_nxt;
      end else begin
        sum_r   <= sum_nxt;
        tally_r <= tally_nxt;
      end
      out_valid_r <= cmd.link || cmd.refuse;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      a_r      <= in_from_node;
      b_r      <= in_to_node;
      weight_r <= in_edge_weight[WB-1:0];
    end
    cur_r <= cur_nxt;
    if (cmd.walk_a && found) ra_r <= cur_r;
    if (cmd.link || cmd.refuse) begin
      out_acc_r   <= merge;
      out_sum_r   <= sum_nxt;
      out_tally_r <= tally_nxt;
      out_cmp_r   <= (NW'(tally_nxt) >= target);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_total_weight = out_sum_r;
  assign out_tree_edges   = out_tally_r;
  assign out_complete     = out_cmp_r;

  `ASSERT_NEXT(a_out_after_cmd, clk, rst_n, cmd.link || cmd.refuse, out_valid_r)
  `ASSERT_NEXT(a_out_single, clk, rst_n, out_valid_r, !out_valid_r)
  `ASSERT_NEXT(a_sum_mono, clk, rst_n, !cmd.clr, sum_r >= $past(sum_r))

endmodule

@@ hdl/kruskal_union_find_mst.sv @@
// Kruskal MST accumulator over a union-find parent table; one result per edge.
// A refused edge is answered from the check; otherwise the block walks from endpoint a,
// then from endpoint b, to its root (one parent memory read a step) and links the roots.
// A restart edge first runs a clearing pass over the parent memory.
// Throughput: the next edge can transfer in the cycle in which the previous result is shown.
// Reset: clearing pass with busy high; receiver cannot stall.
module kruskal_union_find_mst #(
  parameter int MAX_VERTICES = kufm_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = kufm_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_restart,
  input  logic [kufm_pkg::NODE_W-1:0]       in_from_node,
  input  logic [kufm_pkg::NODE_W-1:0]       in_to_node,
  input  logic [kufm_pkg::EWEIGHT_W-1:0]    in_edge_weight,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic [kufm_pkg::SUM_W-1:0]        out_total_weight,
  output logic [kufm_pkg::TALLY_W-1:0]      out_tree_edges,
  output logic                              out_complete,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kufm_pkg::VCOUNT_W-1:0]     cfg_vertex_count
);

  kufm_pkg::cmd_t cmd;
  kufm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  kufm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_restart (in_restart),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd)
  );

  kufm_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .in_edge_weight   (in_edge_weight),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_total_weight (out_total_weight),
    .out_tree_edges   (out_tree_edges),
    .out_complete     (out_complete)
  );

endmodule
